// ----- rtl/core/trc_pkg.sv -----
// Shared types and constants for the TFTP read client.
// Used by every module of the block; has no dependencies of its own.
package trc_pkg;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 88;

    typedef enum logic [1:0] {
        MODE_START  = 2'd0,
        MODE_PACKET = 2'd1,
        MODE_TICK   = 2'd2
    } mode_t;

    localparam logic [15:0] OP_RRQ   = 16'd1;
    localparam logic [15:0] OP_WRQ   = 16'd2;
    localparam logic [15:0] OP_DATA  = 16'd3;
    localparam logic [15:0] OP_ACK   = 16'd4;
    localparam logic [15:0] OP_ERROR = 16'd5;

    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_RRQ  = 2'd1;
    localparam logic [1:0] SEND_ACK  = 2'd2;
    localparam logic [1:0] SEND_ERR  = 2'd3;

    localparam logic [15:0] ERR_DISK_FULL  = 16'd3;
    localparam logic [15:0] ERR_ILLEGAL_OP = 16'd4;

    localparam logic [1:0] REG_BLOCK_SIZE    = 2'd0;
    localparam logic [1:0] REG_MAX_RETRIES   = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [15:0] BLOCK_SIZE_RST    = 16'd512;
    localparam logic [7:0]  MAX_RETRIES_RST   = 8'd5;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd10000;

    localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_CODE_RECV = 2'd1;
    localparam logic [1:0] PHASE_CODE_END  = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RECV = 3'b010,
        PH_END  = 3'b100
    } phase_t;

    typedef struct packed {
        logic [15:0] block_size;
        logic [7:0]  max_retries;
        logic [15:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] opcode;
        logic [15:0] block_word;
        logic [15:0] payload_length;
        logic [1:0]  store_status;
        logic [15:0] stored_bytes;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] send_block;
        logic [15:0] send_error_code;
        logic [1:0]  phase_now;
        logic        start_refused;
        logic        transfer_done;
        logic [31:0] byte_total;
        logic [15:0] error_seen;
    } res_item_t;

    function automatic logic [1:0] phase_code(phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_RECV: code = PHASE_CODE_RECV;
            PH_END:  code = PHASE_CODE_END;
            default: code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/core/trc_cfg_regs.sv -----
// Configuration registers of the TFTP read client.
// Depends on trc_pkg for the register indexes and reset values.
module trc_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output trc_pkg::cfg_t       cfg
);
    import trc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_BLOCK_SIZE:    cfg_next.block_size    = cfg_data;
                REG_MAX_RETRIES:   cfg_next.max_retries   = cfg_data[7:0];
                REG_TIMEOUT_TICKS: cfg_next.timeout_ticks = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.block_size    <= BLOCK_SIZE_RST;
            cfg_reg.max_retries   <= MAX_RETRIES_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/trc_in_reg.sv -----
// Input register of the TFTP read client: holds one accepted beat.
// Depends on trc_pkg for the input item type.
module trc_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  trc_pkg::in_item_t   s_item,
    input  logic                take,
    output logic                item_valid,
    output trc_pkg::in_item_t   item
);
    import trc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register may refill in the same cycle its content moves on.
    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ----- rtl/core/trc_engine.sv -----
// Transfer state and per-item update logic of the TFTP read client.
// Depends on trc_pkg for types, opcodes and phase encodings.
module trc_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,
    input  trc_pkg::in_item_t   item,
    input  trc_pkg::cfg_t       cfg,
    output trc_pkg::res_item_t  result
);
    import trc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] last_block_reg, last_block_next;
    logic [7:0]  retry_reg, retry_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [15:0] error_reg, error_next;

    logic [1:0]  rs_kind;
    logic [15:0] rs_block;
    logic [7:0]  rs_retry;
    logic [15:0] expect_block;
    logic        in_order;

    // A resend repeats the read request until the first block has arrived.
    assign rs_kind      = (last_block_reg == 16'd0) ? SEND_RRQ : SEND_ACK;
    assign rs_block     = last_block_reg;
    assign rs_retry     = (retry_reg == 8'hFF) ? retry_reg : retry_reg + 8'd1;
    assign expect_block = last_block_reg + 16'd1;
    assign in_order     = (item.block_word != 16'd0) && (item.block_word == expect_block);

    always_comb begin
        phase_next      = phase_reg;
        last_block_next = last_block_reg;
        retry_next      = retry_reg;
        timeout_next    = timeout_reg;
        bytes_next      = bytes_reg;
        error_next      = error_reg;
        result          = '0;
        result.send_kind = SEND_NONE;

        case (item.mode)
            MODE_START: begin
                if (phase_reg == PH_END) begin
                    result.start_refused = 1'b1;
                end else begin
                    phase_next       = PH_RECV;
                    last_block_next  = 16'd0;
                    timeout_next     = cfg.timeout_ticks;
                    bytes_next       = 32'd0;
                    error_next       = 16'd0;
                    retry_next       = 8'd0;
                    result.send_kind = SEND_RRQ;
                end
            end
            MODE_PACKET: begin
                if (phase_reg == PH_RECV) begin
                    if (item.opcode == OP_DATA) begin
                        timeout_next = cfg.timeout_ticks;
                        if (!in_order) begin
                            result.send_kind = rs_kind;
                            if (rs_kind == SEND_ACK) begin
                                result.send_block = rs_block;
                            end
                            retry_next = rs_retry;
                        end else if (item.store_status == ST_STORED) begin
                            last_block_next   = item.block_word;
                            bytes_next        = bytes_reg + {16'd0, item.stored_bytes};
                            result.send_kind  = SEND_ACK;
                            result.send_block = item.block_word;
                            retry_next        = 8'd0;
                            if (item.payload_length < cfg.block_size) begin
                                phase_next = PH_END;
                            end
                        end else if (item.store_status == ST_FULL) begin
                            error_next             = ERR_DISK_FULL;
                            result.send_kind       = SEND_ERR;
                            result.send_error_code = ERR_DISK_FULL;
                            phase_next             = PH_IDLE;
                        end
                    end else if (item.opcode == OP_ERROR) begin
                        timeout_next = cfg.timeout_ticks;
                        error_next   = item.block_word;
                        phase_next   = PH_IDLE;
                    end else if (item.opcode == OP_RRQ || item.opcode == OP_WRQ ||
                                 item.opcode == OP_ACK) begin
                        result.send_kind       = SEND_ERR;
                        result.send_error_code = ERR_ILLEGAL_OP;
                        timeout_next           = cfg.timeout_ticks;
                    end
                end
            end
            MODE_TICK: begin
                if (phase_reg == PH_END) begin
                    result.transfer_done = 1'b1;
                    phase_next           = PH_IDLE;
                end else if (phase_reg == PH_RECV) begin
                    if (timeout_reg <= 16'd1) begin
                        result.send_kind = rs_kind;
                        if (rs_kind == SEND_ACK) begin
                            result.send_block = rs_block;
                        end
                        retry_next   = rs_retry;
                        timeout_next = cfg.timeout_ticks;
                    end else begin
                        timeout_next = timeout_reg - 16'd1;
                    end
                    if (retry_next > cfg.max_retries) begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        result.phase_now  = phase_code(phase_next);
        result.byte_total = bytes_next;
        result.error_seen = error_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            last_block_reg <= 16'd0;
            retry_reg      <= 8'd0;
            timeout_reg    <= 16'd0;
            bytes_reg      <= 32'd0;
            error_reg      <= 16'd0;
        end else if (take) begin
            phase_reg      <= phase_next;
            last_block_reg <= last_block_next;
            retry_reg      <= retry_next;
            timeout_reg    <= timeout_next;
            bytes_reg      <= bytes_next;
            error_reg      <= error_next;
        end
    end

endmodule

// ----- rtl/core/trc_out_reg.sv -----
// Result register of the TFTP read client, holding one beat for the receiver.
// Depends on trc_pkg for the result item type.
module trc_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  trc_pkg::res_item_t  result,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output trc_pkg::res_item_t  m_item
);
    import trc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    res_item_t item_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_item   = item_reg;

    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= result;
        end
    end

endmodule

// ----- rtl/core/tftp_read_client.sv -----
// Top level of the TFTP read client, receive side of a read transfer.
// Depends on trc_pkg, trc_cfg_regs, trc_in_reg, trc_engine and trc_out_reg.
//
// Usage:
//   The s_ channel carries one item per beat: a start request, a received
//   packet header with the sink's store answer, or a timer tick, selected
//   by s_tuser. Every item gives exactly one beat on the m_ channel, whose
//   m_tuser names the packet to send (none, read request, ack or error).
//   The cfg channel writes block_size, max_retries and timeout_ticks by
//   index; cfg_ready is always high. Write it only while the block is idle.
//   An accepted item waits in the input register and is processed into the
//   result register as soon as that register can load. Throughput is one
//   item per cycle while the receiver keeps up; the transfer state is
//   updated by a single register stage of compare-and-update logic.
//   Reset clears the transfer state to idle, empties both registers and
//   restores the register defaults (512, 5, 10000).
//   When the receiver stalls, the result register holds its beat, one more
//   input beat is taken into the input register, and s_tready then falls
//   until m_tready returns.
module tftp_read_client (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // opcode, block_word, payload_length, store_status, stored_bytes, zero pad
    input  logic [71:0]  s_tdata,
    // mode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // send_block, send_error_code, phase_now, start_refused, transfer_done,
    // byte_total, error_seen, zero pad
    output logic [87:0]  m_tdata,
    // send_kind
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import trc_pkg::*;

    cfg_t      cfg;
    in_item_t  s_item;
    in_item_t  item;
    logic      item_valid;
    logic      can_load;
    logic      take;
    res_item_t result;
    res_item_t m_item;

    assign s_item.mode           = s_tuser;
    assign s_item.opcode         = s_tdata[15:0];
    assign s_item.block_word     = s_tdata[31:16];
    assign s_item.payload_length = s_tdata[47:32];
    assign s_item.store_status   = s_tdata[49:48];
    assign s_item.stored_bytes   = s_tdata[65:50];

    assign take = item_valid && can_load;

    trc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    trc_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    trc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (item),
        .cfg     (cfg),
        .result  (result)
    );

    trc_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take),
        .result   (result),
        .can_load (can_load),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_item   (m_item)
    );

    assign m_tuser = m_item.send_kind;
    assign m_tdata = {4'd0,
                      m_item.error_seen,
                      m_item.byte_total,
                      m_item.transfer_done,
                      m_item.start_refused,
                      m_item.phase_now,
                      m_item.send_error_code,
                      m_item.send_block};

endmodule
